// File: rtl/clq_pkg.sv
`timescale 1ns / 1ps
package clq_pkg;

	localparam int COORD_BITS     = 24;
	localparam int CELLS_PER_AXIS = 32;
	localparam int CELL_BITS      = $clog2(CELLS_PER_AXIS);
	localparam int CIDX_BITS      = 3 * CELL_BITS;
	localparam int CELL_COUNT     = CELLS_PER_AXIS * CELLS_PER_AXIS * CELLS_PER_AXIS;
	localparam int MAX_PARTICLES  = 4096;
	localparam int PID_BITS       = $clog2(MAX_PARTICLES);
	localparam int PTR_BITS       = PID_BITS + 1;
	localparam int MAX_HITS       = 64;
	localparam int CNT_BITS       = 7;
	localparam int VAL_BITS       = COORD_BITS + 3;
	localparam int SQ_BITS        = 2 * COORD_BITS;
	localparam int SUM_BITS       = SQ_BITS + 2;
	localparam int DCNT_BITS      = $clog2(CELL_BITS + 1);
	localparam int CMDQ_DEPTH     = 2;
	localparam int RESQ_DEPTH     = 4;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_BUILD = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_NOGRID = 2'd2;

	localparam logic [PTR_BITS-1:0] EMPTY_MARK = PTR_BITS'(MAX_PARTICLES);

	typedef enum logic [1:0] {
		K_LOAD  = 2'd0,
		K_BUILD = 2'd1,
		K_QUERY = 2'd2,
		K_NOP   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                       kind;
		logic [PID_BITS-1:0]         pid;
		logic [2:0][COORD_BITS-1:0]  pos;
		logic [COORD_BITS-1:0]       rad;
		logic [SQ_BITS-1:0]          r2;
	} cmd_t;

	typedef struct packed {
		logic [PID_BITS-1:0] hit_id;
		logic                is_match;
		logic                last;
		logic [CNT_BITS-1:0] count;
		logic                ovf;
		logic [1:0]          status;
	} res_t;

	typedef struct packed {
		logic                        start;
		logic [2:0][VAL_BITS-1:0]    v;
		logic [2:0][COORD_BITS-1:0]  range;
	} div_req_t;

	typedef struct packed {
		logic                        done;
		logic [2:0][CELL_BITS-1:0]   cidx;
		logic [2:0]                  neg;
		logic [2:0]                  over;
	} div_rsp_t;

endpackage

// File: rtl/cell_list_build_and_radius_query.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Fields
// input     in         push / full          operation particle_id pos_x pos_y pos_z radius
// result    out        empty / pop          hit_id is_match last match_count overflow status
//
// A load or an unknown operation is answered from the emit state with one result beat.
// A build sweeps the whole cell head table, one entry per cycle, then places each loaded
// particle in turn through the serial cell divider and the registered memory reads.
// A query finds its cell range with the divider, visits each cell in the range, walks each
// particle chained there and ends with a final beat; each memory has one read port.
// Reset clears control state only; the head table is cleared by every build.
// Either side may stall: results wait in a four-beat queue and commands in a two-beat queue.
module cell_list_build_and_radius_query (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  operation,
	input  logic [11:0] particle_id,
	input  logic [23:0] pos_x,
	input  logic [23:0] pos_y,
	input  logic [23:0] pos_z,
	input  logic [23:0] radius,
	output logic        empty,
	input  logic        pop,
	output logic [11:0] hit_id,
	output logic        is_match,
	output logic        last,
	output logic [6:0]  match_count,
	output logic        overflow,
	output logic [1:0]  status
);
	import clq_pkg::*;

	cmd_t     cmd;
	logic     cmd_valid, cmd_pop;
	div_req_t div_req;
	div_rsp_t div_rsp;
	res_t     res_item, head;
	logic     res_push, res_full;

	clq_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.operation   (operation),
		.particle_id (particle_id),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.radius      (radius),
		.cmd_valid   (cmd_valid),
		.cmd_pop     (cmd_pop),
		.cmd         (cmd)
	);

	clq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	clq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.res_push  (res_push),
		.res_item  (res_item),
		.res_full  (res_full)
	);

	clq_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_item (res_item),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.head     (head)
	);

	assign hit_id      = head.hit_id;
	assign is_match    = head.is_match;
	assign last        = head.last;
	assign match_count = head.count;
	assign overflow    = head.ovf;
	assign status      = head.status;

endmodule

// File: rtl/clq_front.sv
`timescale 1ns / 1ps
module clq_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [1:0]                   operation,
	input  logic [11:0]                  particle_id,
	input  logic [23:0]                  pos_x,
	input  logic [23:0]                  pos_y,
	input  logic [23:0]                  pos_z,
	input  logic [23:0]                  radius,
	output logic                         cmd_valid,
	input  logic                         cmd_pop,
	output clq_pkg::cmd_t                cmd
);
	import clq_pkg::*;

	cmd_t       ent_q [CMDQ_DEPTH];
	cmd_t       item;
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	always_comb begin
		case (operation)
			OP_LOAD:  item.kind = K_LOAD;
			OP_BUILD: item.kind = K_BUILD;
			OP_QUERY: item.kind = K_QUERY;
			default:  item.kind = K_NOP;
		endcase
		item.pid    = particle_id[PID_BITS-1:0];
		item.pos[0] = pos_x[COORD_BITS-1:0];
		item.pos[1] = pos_y[COORD_BITS-1:0];
		item.pos[2] = pos_z[COORD_BITS-1:0];
		item.rad    = radius[COORD_BITS-1:0];
		item.r2     = SQ_BITS'(radius) * SQ_BITS'(radius);
	end

	assign full      = (cnt_q == 2'(CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/clq_div.sv
`timescale 1ns / 1ps
module clq_div (
	input  logic               clk,
	input  logic               arst_n,
	input  clq_pkg::div_req_t  req,
	output clq_pkg::div_rsp_t  rsp
);
	import clq_pkg::*;

	logic                   busy_q, done_q;
	logic [DCNT_BITS-1:0]   cnt_q;
	logic [COORD_BITS-1:0]  rem_q [3];
	logic [COORD_BITS-1:0]  rng_q [3];
	logic [CELL_BITS-1:0]   quo_q [3];
	logic [2:0]             neg_q, over_q, zero_q;
	logic [COORD_BITS:0]    rem2 [3];
	logic [COORD_BITS:0]    nrem [3];
	logic [2:0]             ge;
	logic [2:0]             s_neg, s_over;

	always_comb begin
		rsp.done = done_q;
		for (int a = 0; a < 3; a++) begin
			rem2[a]   = {rem_q[a], 1'b0};
			ge[a]     = (rem2[a] >= {1'b0, rng_q[a]});
			nrem[a]   = ge[a] ? (rem2[a] - {1'b0, rng_q[a]}) : rem2[a];
			s_neg[a]  = req.v[a][VAL_BITS-1];
			s_over[a] = !s_neg[a] && (req.v[a] >= VAL_BITS'(req.range[a]));
			rsp.cidx[a] = zero_q[a] ? '0 : quo_q[a];
			rsp.neg[a]  = !zero_q[a] && neg_q[a];
			rsp.over[a] = !zero_q[a] && over_q[a];
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			if (req.start) begin
				rng_q[a]  <= req.range[a];
				zero_q[a] <= (req.range[a] == '0);
				neg_q[a]  <= s_neg[a];
				over_q[a] <= s_over[a];
				rem_q[a]  <= (s_neg[a] || s_over[a]) ? '0 : req.v[a][COORD_BITS-1:0];
				quo_q[a]  <= '0;
			end else if (busy_q) begin
				rem_q[a] <= nrem[a][COORD_BITS-1:0];
				quo_q[a] <= {quo_q[a][CELL_BITS-2:0], ge[a]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DCNT_BITS'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_BITS'(CELL_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DCNT_BITS'(1);
				if (cnt_q == DCNT_BITS'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

// File: rtl/clq_outq.sv
`timescale 1ns / 1ps
module clq_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           res_push,
	input  clq_pkg::res_t  res_item,
	output logic           res_full,
	output logic           empty,
	input  logic           pop,
	output clq_pkg::res_t  head
);
	import clq_pkg::*;

	localparam int PB = $clog2(RESQ_DEPTH);

	res_t          ent_q [RESQ_DEPTH];
	logic [PB-1:0] wr_q, rd_q;
	logic [PB:0]   cnt_q;
	logic          do_push, do_pop;

	assign res_full = (cnt_q == (PB+1)'(RESQ_DEPTH));
	assign empty    = (cnt_q == '0);
	assign head     = ent_q[rd_q];
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= res_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PB'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PB'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (PB+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (PB+1)'(1);
			end
		end
	end

endmodule

// File: rtl/clq_back.sv
`timescale 1ns / 1ps
module clq_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  clq_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	output clq_pkg::div_req_t  div_req,
	input  clq_pkg::div_rsp_t  div_rsp,
	output logic               res_push,
	output clq_pkg::res_t      res_item,
	input  logic               res_full
);
	import clq_pkg::*;

	typedef enum logic [17:0] {
		S_IDLE    = 18'd1 << 0,
		S_EMIT    = 18'd1 << 1,
		S_CLEAR   = 18'd1 << 2,
		S_BRD     = 18'd1 << 3,
		S_BGO     = 18'd1 << 4,
		S_BWAIT   = 18'd1 << 5,
		S_BHEAD   = 18'd1 << 6,
		S_BLINK   = 18'd1 << 7,
		S_QLOGO   = 18'd1 << 8,
		S_QLOWAIT = 18'd1 << 9,
		S_QHIGO   = 18'd1 << 10,
		S_QHIWAIT = 18'd1 << 11,
		S_QCELL   = 18'd1 << 12,
		S_QHEAD   = 18'd1 << 13,
		S_QD1     = 18'd1 << 14,
		S_QD2     = 18'd1 << 15,
		S_QNEXT   = 18'd1 << 16,
		S_QEND    = 18'd1 << 17
	} state_t;

	logic [COORD_BITS-1:0] store_x [MAX_PARTICLES];
	logic [COORD_BITS-1:0] store_y [MAX_PARTICLES];
	logic [COORD_BITS-1:0] store_z [MAX_PARTICLES];
	logic [PTR_BITS-1:0]   chain_next [MAX_PARTICLES];
	logic [PTR_BITS-1:0]   cell_head [CELL_COUNT];

	state_t                state_q;
	logic                  grid_q;
	logic [PTR_BITS-1:0]   cnt_q, bi_q;
	logic [COORD_BITS-1:0] low_q [3];
	logic [COORD_BITS-1:0] high_q [3];
	logic [COORD_BITS-1:0] cen_q [3];
	logic [COORD_BITS-1:0] rad_q;
	logic [SQ_BITS-1:0]    r2_q;
	logic [CNT_BITS-1:0]   n_q;
	logic                  ovf_q, lo_emp_q;
	logic [1:0]            st_q;
	logic [CIDX_BITS-1:0]  clr_q, bcell_q;
	logic [CELL_BITS-1:0]  lo_q [3];
	logic [CELL_BITS-1:0]  hi_q [3];
	logic [CELL_BITS-1:0]  ci_q, cj_q, ck_q;
	logic [PID_BITS-1:0]   cur_q, pend_q;

	logic [SQ_BITS-1:0]    sq_s1 [3];
	logic [2:0]            inb_s1;
	logic [PTR_BITS-1:0]   nxt_s1;

	logic [COORD_BITS-1:0] st_rd [3];
	logic [PTR_BITS-1:0]   ch_rd, hd_rd;
	logic [PID_BITS-1:0]   st_raddr;
	logic [CIDX_BITS-1:0]  hd_raddr, hd_waddr, qcell;
	logic [PTR_BITS-1:0]   hd_wdata;
	logic                  hd_we, st_we, ld_full;
	logic [COORD_BITS-1:0] dd [3];
	logic [SUM_BITS-1:0]   sum;
	logic                  hit, room, qd2_push, qd2_stall;
	logic [CELL_BITS-1:0]  pcell [3];
	logic [VAL_BITS-1:0]   base [3];
	logic                  hi_neg_any;

	assign qcell    = {ci_q, cj_q, ck_q};
	assign ld_full  = (cnt_q >= PTR_BITS'(MAX_PARTICLES)) || (32'(cmd.pid) >= MAX_PARTICLES);
	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;
	assign st_we    = cmd_pop && (cmd.kind == K_LOAD) && !ld_full;
	assign hd_we    = (state_q == S_CLEAR) || (state_q == S_BLINK);
	assign hd_waddr = (state_q == S_CLEAR) ? clr_q : bcell_q;
	assign hd_wdata = (state_q == S_CLEAR) ? EMPTY_MARK : bi_q;
	assign hd_raddr = (state_q == S_BHEAD) ? bcell_q : qcell;

	always_comb begin
		case (state_q)
			S_QHEAD: st_raddr = hd_rd[PID_BITS-1:0];
			S_QD2:   st_raddr = nxt_s1[PID_BITS-1:0];
			default: st_raddr = bi_q[PID_BITS-1:0];
		endcase
	end

	always_comb begin
		hi_neg_any = 1'b0;
		for (int a = 0; a < 3; a++) begin
			dd[a] = (st_rd[a] >= cen_q[a]) ? (st_rd[a] - cen_q[a]) : (cen_q[a] - st_rd[a]);
			pcell[a] = div_rsp.neg[a] ? '0 :
				(div_rsp.over[a] ? CELL_BITS'(CELLS_PER_AXIS - 1) : div_rsp.cidx[a]);
			base[a] = VAL_BITS'(cen_q[a]) - VAL_BITS'(low_q[a]);
			div_req.range[a] = high_q[a] - low_q[a];
			case (state_q)
				S_QLOGO: div_req.v[a] = base[a] - VAL_BITS'(rad_q);
				S_QHIGO: div_req.v[a] = base[a] + VAL_BITS'(rad_q);
				default: div_req.v[a] = VAL_BITS'(st_rd[a]) - VAL_BITS'(low_q[a]);
			endcase
			hi_neg_any = hi_neg_any | div_rsp.neg[a];
		end
		div_req.start = (state_q == S_BGO) || (state_q == S_QLOGO) || (state_q == S_QHIGO);
	end

	assign sum       = SUM_BITS'(sq_s1[0]) + SUM_BITS'(sq_s1[1]) + SUM_BITS'(sq_s1[2]);
	assign hit       = (&inb_s1) && (sum < SUM_BITS'(r2_q));
	assign room      = (n_q < CNT_BITS'(MAX_HITS));
	assign qd2_push  = (state_q == S_QD2) && hit && room && (n_q != '0);
	assign qd2_stall = qd2_push && res_full;

	always_comb begin
		res_item = '{hit_id: '0, is_match: 1'b0, last: 1'b1, count: '0, ovf: 1'b0,
			status: st_q};
		res_push = 1'b0;
		case (state_q)
			S_EMIT: begin
				res_push = !res_full;
			end
			S_QD2: begin
				res_push = qd2_push && !res_full;
				res_item.hit_id   = pend_q;
				res_item.is_match = 1'b1;
				res_item.last     = 1'b0;
			end
			S_QEND: begin
				res_push = !res_full;
				if (n_q != '0) begin
					res_item.hit_id   = pend_q;
					res_item.is_match = 1'b1;
					res_item.count    = n_q;
					res_item.ovf      = ovf_q;
				end
			end
			default: res_push = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_x[cmd.pid[PID_BITS-1:0]] <= cmd.pos[0];
			store_y[cmd.pid[PID_BITS-1:0]] <= cmd.pos[1];
			store_z[cmd.pid[PID_BITS-1:0]] <= cmd.pos[2];
		end
		st_rd[0] <= store_x[st_raddr];
		st_rd[1] <= store_y[st_raddr];
		st_rd[2] <= store_z[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_BLINK) begin
			chain_next[bi_q[PID_BITS-1:0]] <= hd_rd;
		end
		ch_rd <= chain_next[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (hd_we) begin
			cell_head[hd_waddr] <= hd_wdata;
		end
		hd_rd <= cell_head[hd_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_QD1) begin
			for (int a = 0; a < 3; a++) begin
				sq_s1[a]  <= SQ_BITS'(dd[a]) * SQ_BITS'(dd[a]);
				inb_s1[a] <= (dd[a] < rad_q);
			end
			nxt_s1 <= ch_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			grid_q   <= 1'b0;
			cnt_q    <= '0;
			bi_q     <= '0;
			n_q      <= '0;
			ovf_q    <= 1'b0;
			lo_emp_q <= 1'b0;
			st_q     <= ST_OK;
			clr_q    <= '0;
			bcell_q  <= '0;
			rad_q    <= '0;
			r2_q     <= '0;
			ci_q     <= '0;
			cj_q     <= '0;
			ck_q     <= '0;
			cur_q    <= '0;
			pend_q   <= '0;
			for (int a = 0; a < 3; a++) begin
				low_q[a]  <= '0;
				high_q[a] <= '0;
				cen_q[a]  <= '0;
				lo_q[a]   <= '0;
				hi_q[a]   <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						st_q <= ST_OK;
						case (cmd.kind)
							K_LOAD: begin
								if (ld_full) begin
									st_q <= ST_FULL;
								end else begin
									for (int a = 0; a < 3; a++) begin
										if (cnt_q == '0 || cmd.pos[a] < low_q[a]) begin
											low_q[a] <= cmd.pos[a];
										end
										if (cnt_q == '0 || cmd.pos[a] > high_q[a]) begin
											high_q[a] <= cmd.pos[a];
										end
									end
									cnt_q  <= cnt_q + PTR_BITS'(1);
									grid_q <= 1'b0;
								end
								state_q <= S_EMIT;
							end
							K_BUILD: begin
								clr_q   <= '0;
								state_q <= S_CLEAR;
							end
							K_QUERY: begin
								if (!grid_q) begin
									st_q    <= ST_NOGRID;
									state_q <= S_EMIT;
								end else begin
									for (int a = 0; a < 3; a++) begin
										cen_q[a] <= cmd.pos[a];
									end
									rad_q   <= cmd.rad;
									r2_q    <= cmd.r2;
									n_q     <= '0;
									ovf_q   <= 1'b0;
									state_q <= S_QLOGO;
								end
							end
							default: state_q <= S_EMIT;
						endcase
					end
				end
				S_EMIT: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + CIDX_BITS'(1);
					if (clr_q == CIDX_BITS'(CELL_COUNT - 1)) begin
						bi_q <= '0;
						if (cnt_q == '0) begin
							grid_q  <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_BRD;
						end
					end
				end
				S_BRD:   state_q <= S_BGO;
				S_BGO:   state_q <= S_BWAIT;
				S_BWAIT: begin
					if (div_rsp.done) begin
						bcell_q <= {pcell[0], pcell[1], pcell[2]};
						state_q <= S_BHEAD;
					end
				end
				S_BHEAD: state_q <= S_BLINK;
				S_BLINK: begin
					bi_q <= bi_q + PTR_BITS'(1);
					if (bi_q + PTR_BITS'(1) == cnt_q) begin
						grid_q  <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_BRD;
					end
				end
				S_QLOGO: state_q <= S_QLOWAIT;
				S_QLOWAIT: begin
					if (div_rsp.done) begin
						for (int a = 0; a < 3; a++) begin
							lo_q[a] <= div_rsp.neg[a] ? '0 : div_rsp.cidx[a];
						end
						lo_emp_q <= |div_rsp.over;
						state_q  <= S_QHIGO;
					end
				end
				S_QHIGO: state_q <= S_QHIWAIT;
				S_QHIWAIT: begin
					if (div_rsp.done) begin
						for (int a = 0; a < 3; a++) begin
							hi_q[a] <= pcell[a];
						end
						ci_q <= lo_q[0];
						cj_q <= lo_q[1];
						ck_q <= lo_q[2];
						if (lo_emp_q || hi_neg_any) begin
							state_q <= S_QEND;
						end else begin
							state_q <= S_QCELL;
						end
					end
				end
				S_QCELL: state_q <= S_QHEAD;
				S_QHEAD: begin
					if (hd_rd == EMPTY_MARK) begin
						state_q <= S_QNEXT;
					end else begin
						cur_q   <= hd_rd[PID_BITS-1:0];
						state_q <= S_QD1;
					end
				end
				S_QD1: state_q <= S_QD2;
				S_QD2: begin
					if (!qd2_stall) begin
						if (hit && !room) begin
							ovf_q   <= 1'b1;
							state_q <= S_QEND;
						end else begin
							if (hit) begin
								pend_q <= cur_q;
								n_q    <= n_q + CNT_BITS'(1);
							end
							if (nxt_s1 == EMPTY_MARK) begin
								state_q <= S_QNEXT;
							end else begin
								cur_q   <= nxt_s1[PID_BITS-1:0];
								state_q <= S_QD1;
							end
						end
					end
				end
				S_QNEXT: begin
					state_q <= S_QCELL;
					if (ck_q != hi_q[2]) begin
						ck_q <= ck_q + CELL_BITS'(1);
					end else begin
						ck_q <= lo_q[2];
						if (cj_q != hi_q[1]) begin
							cj_q <= cj_q + CELL_BITS'(1);
						end else begin
							cj_q <= lo_q[1];
							if (ci_q != hi_q[0]) begin
								ci_q <= ci_q + CELL_BITS'(1);
							end else begin
								state_q <= S_QEND;
							end
						end
					end
				end
				S_QEND: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	a_hits_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_BITS'(MAX_HITS))
		else $error("match count above cap");

	a_grid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(grid_q) |-> ($past(state_q) == S_BLINK || $past(state_q) == S_CLEAR))
		else $error("grid marked ready outside a build");

endmodule

// File: tb/cell_search_checker.sv
`timescale 1ns / 1ps
module cell_search_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  operation,
	input  logic [11:0] particle_id,
	input  logic [23:0] pos_x,
	input  logic [23:0] pos_y,
	input  logic [23:0] pos_z,
	input  logic [23:0] radius,
	input  logic        empty,
	input  logic        pop,
	input  logic [11:0] hit_id,
	input  logic        is_match,
	input  logic        last,
	input  logic [6:0]  match_count,
	input  logic        overflow,
	input  logic [1:0]  status,
	output int          errors,
	output int          pending
);
	import clq_pkg::*;

	res_t        awaited_hits[$];
	longint      part_pos[3][MAX_PARTICLES];
	int          chain_link[MAX_PARTICLES];
	int          head_of[CELL_COUNT];
	longint      lo_edge[3];
	longint      hi_edge[3];
	int          stored_cnt;
	bit          grid_valid;

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic longint cell_floor(longint v, longint span);
		if (span == 0)
			return 0;
		if (v < 0)
			return -1;
		return v * CELLS_PER_AXIS / span;
	endfunction

	function automatic longint clamp_cell(longint c);
		if (c < 0)
			return 0;
		if (c > CELLS_PER_AXIS - 1)
			return CELLS_PER_AXIS - 1;
		return c;
	endfunction

	task automatic clear_state();
		for (int i = 0; i < CELL_COUNT; i++)
			head_of[i] = MAX_PARTICLES;
		for (int a = 0; a < 3; a++) begin
			lo_edge[a] = 0;
			hi_edge[a] = 0;
		end
		stored_cnt = 0;
		grid_valid = 0;
		awaited_hits.delete();
	endtask

	task automatic build_cells();
		longint c[3];
		int idx;
		for (int i = 0; i < CELL_COUNT; i++)
			head_of[i] = MAX_PARTICLES;
		for (int p = 0; p < stored_cnt; p++) begin
			for (int a = 0; a < 3; a++)
				c[a] = clamp_cell(cell_floor(part_pos[a][p] - lo_edge[a],
					hi_edge[a] - lo_edge[a]));
			idx = int'((c[0] * CELLS_PER_AXIS + c[1]) * CELLS_PER_AXIS + c[2]);
			chain_link[p] = head_of[idx];
			head_of[idx] = p;
		end
		grid_valid = 1;
	endtask

	task automatic search_sphere(longint cen[3], longint r);
		longint lo[3];
		longint hi[3];
		longint base, dx, dy, dz;
		res_t hits[$];
		res_t beat;
		bit ovf;
		int p;
		ovf = 0;
		for (int a = 0; a < 3; a++) begin
			base = cen[a] - lo_edge[a];
			lo[a] = cell_floor(base - r, hi_edge[a] - lo_edge[a]);
			if (lo[a] < 0)
				lo[a] = 0;
			hi[a] = cell_floor(base + r, hi_edge[a] - lo_edge[a]);
			if (hi[a] > CELLS_PER_AXIS - 1)
				hi[a] = CELLS_PER_AXIS - 1;
		end
		for (longint i = lo[0]; i <= hi[0] && !ovf; i++)
			for (longint j = lo[1]; j <= hi[1] && !ovf; j++)
				for (longint k = lo[2]; k <= hi[2] && !ovf; k++) begin
					p = head_of[int'((i * CELLS_PER_AXIS + j) * CELLS_PER_AXIS + k)];
					while (p < MAX_PARTICLES && !ovf) begin
						dx = part_pos[0][p] - cen[0];
						dy = part_pos[1][p] - cen[1];
						dz = part_pos[2][p] - cen[2];
						if (dx < 0) dx = -dx;
						if (dy < 0) dy = -dy;
						if (dz < 0) dz = -dz;
						if (dx < r && dy < r && dz < r && dx*dx + dy*dy + dz*dz < r*r) begin
							if (hits.size() < MAX_HITS) begin
								beat = '0;
								beat.hit_id = PID_BITS'(p);
								beat.is_match = 1'b1;
								hits.push_back(beat);
							end else begin
								ovf = 1;
							end
						end
						p = chain_link[p];
					end
				end
		if (hits.size() == 0) begin
			beat = '0;
			beat.last = 1'b1;
			awaited_hits.push_back(beat);
		end else begin
			hits[hits.size()-1].last = 1'b1;
			hits[hits.size()-1].count = CNT_BITS'(hits.size());
			hits[hits.size()-1].ovf = ovf;
			foreach (hits[n])
				awaited_hits.push_back(hits[n]);
		end
	endtask

	task automatic predict_beat(logic [1:0] op, logic [11:0] pid, longint pt[3], longint r);
		res_t single;
		single = '0;
		single.last = 1'b1;
		if (op == OP_LOAD) begin
			if (stored_cnt >= MAX_PARTICLES || pid >= MAX_PARTICLES) begin
				single.status = ST_FULL;
			end else begin
				for (int a = 0; a < 3; a++) begin
					part_pos[a][pid] = pt[a];
					if (stored_cnt == 0 || pt[a] < lo_edge[a])
						lo_edge[a] = pt[a];
					if (stored_cnt == 0 || pt[a] > hi_edge[a])
						hi_edge[a] = pt[a];
				end
				stored_cnt++;
				grid_valid = 0;
			end
			awaited_hits.push_back(single);
		end else if (op == OP_BUILD) begin
			build_cells();
			awaited_hits.push_back(single);
		end else if (op == OP_QUERY) begin
			if (!grid_valid) begin
				single.status = ST_NOGRID;
				awaited_hits.push_back(single);
			end else begin
				search_sphere(pt, r);
			end
		end else begin
			awaited_hits.push_back(single);
		end
	endtask

	task automatic compare_field(string name, longint want, longint got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		longint pt[3];
		if (!arst_n) begin
			clear_state();
		end else begin
			if (pop && !empty) begin
				if (awaited_hits.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing expected, actual hit_id %0d",
						$time, hit_id);
				end else begin
					want = awaited_hits.pop_front();
					compare_field("hit_id", want.hit_id, hit_id);
					compare_field("is_match", want.is_match, is_match);
					compare_field("last", want.last, last);
					compare_field("match_count", want.count, match_count);
					compare_field("overflow", want.ovf, overflow);
					compare_field("status", want.status, status);
				end
			end
			if (push && !full) begin
				pt[0] = pos_x;
				pt[1] = pos_y;
				pt[2] = pos_z;
				predict_beat(operation, particle_id, pt, longint'(radius));
			end
		end
		pending = awaited_hits.size();
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import clq_pkg::*;

	localparam int STALL_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  operation = '0;
	logic [11:0] particle_id = '0;
	logic [23:0] pos_x = '0;
	logic [23:0] pos_y = '0;
	logic [23:0] pos_z = '0;
	logic [23:0] radius = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [11:0] hit_id;
	logic        is_match;
	logic        last;
	logic [6:0]  match_count;
	logic        overflow;
	logic [1:0]  status;
	int          errors;
	int          pending;

	bit          slot_used[MAX_PARTICLES];
	logic [23:0] slot_pos[3][MAX_PARTICLES];
	int          loaded;
	int          first_free;
	int          items;
	int          pop_hold;
	int          idle_cycles;

	cell_list_build_and_radius_query dut (.*);

	cell_search_checker u_checker (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 15);
		if (roll < 8)
			return 0;
		if (roll < 14)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold > 0) begin
			pop_hold <= pop_hold - 1;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				pop_hold <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send(logic [1:0] op, logic [11:0] pid, logic [23:0] x, logic [23:0] y,
		logic [23:0] z, logic [23:0] r);
		int gap;
		push <= 1'b1;
		operation <= op;
		particle_id <= pid;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		radius <= r;
		forever begin
			@(posedge clk);
			if (!full)
				break;
		end
		items++;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic load(logic [23:0] x, logic [23:0] y, logic [23:0] z);
		int id;
		id = first_free;
		if ($urandom_range(0, 4) == 0) begin
			id = $urandom_range(first_free, first_free + 20);
			if (id > MAX_PARTICLES - 1 || slot_used[id])
				id = first_free;
		end
		slot_used[id] = 1;
		slot_pos[0][id] = x;
		slot_pos[1][id] = y;
		slot_pos[2][id] = z;
		loaded++;
		while (first_free < MAX_PARTICLES && slot_used[first_free])
			first_free++;
		send(OP_LOAD, 12'(id), x, y, z, 24'($urandom));
	endtask

	task automatic build();
		while (first_free < loaded)
			load(24'($urandom), 24'($urandom), 24'($urandom));
		send(OP_BUILD, 12'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
			24'($urandom));
	endtask

	task automatic query_near(int spread, logic [23:0] r);
		int p;
		p = $urandom_range(0, loaded - 1);
		send(OP_QUERY, 12'($urandom), slot_pos[0][p] + 24'($urandom_range(0, spread)),
			slot_pos[1][p] - 24'($urandom_range(0, spread)),
			slot_pos[2][p] + 24'($urandom_range(0, spread)), r);
	endtask

	initial begin
		logic [23:0] hub[3];
		int spread;
		int burst;
		loaded = 0;
		first_free = 0;
		items = 0;
		pop_hold = 0;
		idle_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(OP_QUERY, 12'hfff, 24'h0, 24'h0, 24'h0, 24'h10);
		send(K_NOP, 12'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
			24'($urandom));
		build();
		send(OP_QUERY, 12'h0, 24'h800000, 24'h800000, 24'h0, 24'hffffff);
		load(24'h0, 24'h0, 24'h0);
		load(24'hffffff, 24'hffffff, 24'h0);
		load(24'h800000, 24'h400000, 24'h0);
		load(24'h800000, 24'h400000, 24'h0);
		send(OP_QUERY, 12'h0, 24'h800000, 24'h400000, 24'h0, 24'h100);
		drain();
		build();
		send(OP_QUERY, 12'h0, 24'h800000, 24'h400000, 24'h0, 24'h1);
		send(OP_QUERY, 12'h0, 24'h800000, 24'h400000, 24'h0, 24'h0);
		send(OP_QUERY, 12'h0, 24'h0, 24'h0, 24'h0, 24'hffffff);
		send(OP_QUERY, 12'h0, 24'hffffff, 24'hffffff, 24'hffffff, 24'h1000);
		send(OP_QUERY, 12'h0, 24'h0, 24'hffffff, 24'h0, 24'h0);

		// A dense cluster in one cell, so a small sphere finds more than the cap.
		for (int i = 0; i < 70; i++)
			load(24'h400000 + 24'($urandom_range(0, 255)), 24'h400000 + 24'($urandom_range(0, 255)),
				24'h400000 + 24'($urandom_range(0, 255)));
		build();
		send(OP_QUERY, 12'h0, 24'h400080, 24'h400080, 24'h400080, 24'h1000);

		while (items < 135) begin
			hub[0] = 24'($urandom);
			hub[1] = 24'($urandom);
			hub[2] = 24'($urandom);
			spread = 1 << $urandom_range(8, 20);
			burst = $urandom_range(2, 8);
			for (int i = 0; i < burst; i++)
				if ($urandom_range(0, 5) == 0)
					load(24'($urandom), 24'($urandom), 24'($urandom));
				else
					load(hub[0] + 24'($urandom_range(0, spread)),
						hub[1] + 24'($urandom_range(0, spread)),
						hub[2] + 24'($urandom_range(0, spread)));
			if ($urandom_range(0, 3) == 0)
				send(OP_QUERY, 12'($urandom), hub[0], hub[1], hub[2], 24'($urandom));
			if ($urandom_range(0, 3) == 0)
				send(K_NOP, 12'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
					24'($urandom));
			build();
			burst = $urandom_range(4, 12);
			for (int i = 0; i < burst; i++)
				if ($urandom_range(0, 40) == 0)
					query_near(spread, 24'hffffff);
				else
					query_near(spread, 24'($urandom_range(0, 2 * spread)));
		end

		build();
		query_near(0, 24'hffffff);
		query_near(1 << 16, 24'h40000);

		drain();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
